// ===== hw/rtl/ecg_pkg.sv =====
// ----------------------------------------------------------------------------
// ecg_pkg
// shared codes, widths and base-set helpers of the edit candidate generator
// ----------------------------------------------------------------------------
package ecg_pkg;

   localparam int SITE_BITS_DEF = 16;
   localparam int POS_BITS      = 16;
   localparam int CODE_BITS     = 4;
   localparam int ALPHA_MAX     = 10;                // diploid alphabet size
   localparam int ALPHA_HAP     = 4;                 // pure bases
   localparam int CAND_BITS     = 2 * ALPHA_MAX + 1; // ins, del, sub slots
   localparam int DEL_SLOT      = ALPHA_MAX;
   localparam int SUB_BASE      = ALPHA_MAX + 1;
   localparam int IDX_BITS      = $clog2(CAND_BITS);

   // input item kinds
   localparam logic [1:0] KIND_BEGIN  = 2'd0;
   localparam logic [1:0] KIND_BASE   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // edit kinds
   localparam logic [1:0] EDIT_INS = 2'd0;
   localparam logic [1:0] EDIT_DEL = 2'd1;
   localparam logic [1:0] EDIT_SUB = 2'd2;

   // base codes
   localparam logic [CODE_BITS-1:0] CODE_A    = 4'd0;
   localparam logic [CODE_BITS-1:0] CODE_C    = 4'd1;
   localparam logic [CODE_BITS-1:0] CODE_G    = 4'd2;
   localparam logic [CODE_BITS-1:0] CODE_T    = 4'd3;
   localparam logic [CODE_BITS-1:0] CODE_Y    = 4'd4;
   localparam logic [CODE_BITS-1:0] CODE_R    = 4'd5;
   localparam logic [CODE_BITS-1:0] CODE_W    = 4'd6;
   localparam logic [CODE_BITS-1:0] CODE_S    = 4'd7;
   localparam logic [CODE_BITS-1:0] CODE_K    = 4'd8;
   localparam logic [CODE_BITS-1:0] CODE_M    = 4'd9;
   localparam logic [CODE_BITS-1:0] CODE_NONE = 4'd10;

   typedef logic [CAND_BITS-1:0] cand_type;

   // codes above none fold onto none
   function automatic logic [CODE_BITS-1:0] norm_code(input logic [CODE_BITS-1:0] code);
      norm_code = (code > CODE_NONE) ? CODE_NONE : code;
   endfunction

   // ambiguity set over A,C,G,T (bit 0 = A)
   function automatic logic [ALPHA_HAP-1:0] iupac_set(input logic [CODE_BITS-1:0] code);
      unique case (code)
         CODE_A:  iupac_set = 4'b0001;
         CODE_C:  iupac_set = 4'b0010;
         CODE_G:  iupac_set = 4'b0100;
         CODE_T:  iupac_set = 4'b1000;
         CODE_Y:  iupac_set = 4'b1010;
         CODE_R:  iupac_set = 4'b0101;
         CODE_W:  iupac_set = 4'b1001;
         CODE_S:  iupac_set = 4'b0110;
         CODE_K:  iupac_set = 4'b1100;
         CODE_M:  iupac_set = 4'b0011;
         default: iupac_set = 4'b0000;
      endcase
   endfunction

   // alphabet bases that the given code does not contain
   function automatic logic [ALPHA_MAX-1:0] missing_set(input logic [CODE_BITS-1:0] code,
                                                         input logic diploid);
      logic [ALPHA_MAX-1:0] m;
      m = '0;
      if (diploid) begin
         for (int j = 0; j < ALPHA_MAX; j++) begin
            m[j] = (code != CODE_BITS'(j));
         end
      end else begin
         m[ALPHA_HAP-1:0] = ~iupac_set(code);
      end
      missing_set = m;
   endfunction

endpackage

// ===== hw/rtl/ecg_emit.sv =====
// ----------------------------------------------------------------------------
// ecg_emit
// holds the candidate slots of one item and drains them lowest slot first
// into the result register, one transfer per cycle while the result port is free
// ----------------------------------------------------------------------------
module ecg_emit #(
   parameter int SITE_BITS = ecg_pkg::SITE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   output logic                          load_ready,
   input  ecg_pkg::cand_type             load_mask,
   input  logic [SITE_BITS-1:0]          load_site,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_edit_kind,
   output logic [SITE_BITS-1:0]          rsp_site,
   output logic [ecg_pkg::CODE_BITS-1:0] rsp_new_base,
   output logic                          rsp_last_of_run
);
   import ecg_pkg::*;

   cand_type                pend_ff, pend_in;
   logic [SITE_BITS-1:0]    site_ff;
   logic                    valid_ff, valid_in;
   logic [1:0]              kind_ff, kind_in;
   logic [SITE_BITS-1:0]    osite_ff;
   logic [CODE_BITS-1:0]    nb_ff, nb_in;
   logic                    last_ff, last_in;

   cand_type                low, rest;
   logic [IDX_BITS-1:0]     idx;
   logic                    out_free, pop;

   assign out_free   = !valid_ff || rsp_ready;
   assign low        = pend_ff & (~pend_ff + CAND_BITS'(1));
   assign rest       = pend_ff & ~low;
   assign busy       = |pend_ff;
   assign pop        = busy && out_free;
   assign load_ready = !busy || (out_free && (rest == '0));

   always_comb begin
      idx = '0;
      for (int i = 0; i < CAND_BITS; i++) begin
         if (low[i]) idx = IDX_BITS'(i);
      end
   end

   always_comb begin
      if (idx < IDX_BITS'(DEL_SLOT)) begin
         kind_in = EDIT_INS;
         nb_in   = CODE_BITS'(idx);
      end else if (idx == IDX_BITS'(DEL_SLOT)) begin
         kind_in = EDIT_DEL;
         nb_in   = '0;
      end else begin
         kind_in = EDIT_SUB;
         nb_in   = CODE_BITS'(idx - IDX_BITS'(SUB_BASE));
      end
      last_in = (rest == '0);
   end

   always_comb begin
      if (load_valid && load_ready) begin
         pend_in = load_mask;
      end else if (pop) begin
         pend_in = rest;
      end else begin
         pend_in = pend_ff;
      end
      valid_in = out_free ? busy : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         site_ff <= load_site;
      end
      if (pop) begin
         kind_ff  <= kind_in;
         osite_ff <= site_ff;
         nb_ff    <= nb_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_edit_kind   = kind_ff;
   assign rsp_site        = osite_ff;
   assign rsp_new_base    = nb_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== hw/rtl/edit_candidate_generator.sv =====
// ----------------------------------------------------------------------------
// edit_candidate_generator
// emits every single-base edit candidate over a streamed template range
// ----------------------------------------------------------------------------
// first result of an item: the slot register loads at the transfer, then the
//   result register takes the lowest slot once the result port is free
// throughput: an item that causes results holds the input until its last slot
//   (up to 20) is drained, one result per cycle while the result port is free;
//   items with no result are taken every cycle while no slots are pending
// reset: synchronous, active high; clears mode, previous base (to none),
//   site, range flag, pending slots and result valid
module edit_candidate_generator #(
   parameter int SITE_BITS = ecg_pkg::SITE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [ecg_pkg::CODE_BITS-1:0] req_base,
   input  logic [ecg_pkg::POS_BITS-1:0]  req_position,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_edit_kind,
   output logic [SITE_BITS-1:0]          rsp_site,
   output logic [ecg_pkg::CODE_BITS-1:0] rsp_new_base,
   output logic                          rsp_last_of_run
);
   import ecg_pkg::*;

   // architectural state
   logic                  mode_ff;
   logic [CODE_BITS-1:0]  prev_ff, prev_in;
   logic [SITE_BITS-1:0]  site_ff, site_in;
   logic                  has_ff, has_in;

   logic                  req_xfer;
   logic [CODE_BITS-1:0]  base_n;
   cand_type              mask;
   logic                  busy;

   assign req_xfer = req_valid && req_ready;
   assign base_n   = norm_code(req_base);

   // candidate slots: insertions low, deletion in the middle, substitutions high,
   // so draining lowest slot first gives the required order
   always_comb begin
      mask    = '0;
      prev_in = prev_ff;
      site_in = site_ff;
      has_in  = has_ff;
      case (req_kind)
         KIND_BEGIN: begin
            prev_in = base_n;
            site_in = SITE_BITS'(req_position);
            has_in  = 1'b0;
         end
         KIND_BASE: begin
            mask[ALPHA_MAX-1:0]          = missing_set(prev_ff, mode_ff);
            mask[DEL_SLOT]               = (base_n != prev_ff);
            mask[CAND_BITS-1:SUB_BASE]   = missing_set(base_n, mode_ff);
            prev_in = base_n;
            site_in = site_ff + SITE_BITS'(1);   // wraps at the site width
            has_in  = 1'b1;
         end
         KIND_FINISH: begin
            // terminal insertions only when the range saw a base
            if (has_ff) mask[ALPHA_MAX-1:0] = missing_set(prev_ff, mode_ff);
            has_in = 1'b0;
         end
         default: begin
            // reserved kind: no results, state untouched
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         prev_ff <= CODE_NONE;
         site_ff <= '0;
         has_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) mode_ff <= csr_write_data;
         if (req_xfer) begin
            prev_ff <= prev_in;
            site_ff <= site_in;
            has_ff  <= has_in;
         end
      end
   end

   // slot register and result register
   ecg_emit #(
      .SITE_BITS (SITE_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (req_valid),
      .load_ready      (req_ready),
      .load_mask       (mask),
      .load_site       (site_ff),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edit_kind   (rsp_edit_kind),
      .rsp_site        (rsp_site),
      .rsp_new_base    (rsp_new_base),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a base transfer always leaves at least one substitution pending
   a_base_makes_work: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == KIND_BASE) |=> busy)
      else $error("base transfer left no pending slots");

   // a result that is not the last of its run must have slots behind it
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> busy)
      else $error("result not marked last but nothing pending");

   // a begin transfer loads the start site
   a_begin_site: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == KIND_BEGIN) |=>
      site_ff == SITE_BITS'($past(req_position)))
      else $error("begin transfer did not load the site");

endmodule
